/* rtl/acg_pkg.sv */
`default_nettype none
package acg_pkg;

  localparam int DATA_W          = 16;
  localparam int LEN_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int MAX_CADENCE_DEF = 5;
  localparam int NUM_WORD_REGS   = 5;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LAST = 3'd5;

  // shared control seen by every history cell
  typedef struct packed {
    logic             load;  // an item updates the history this cycle
    logic             full;  // history holds len entries
    logic [LEN_W-1:0] len;   // effective cadence length
    logic [LEN_W-1:0] off;   // rotation offset, always below len
    logic [LEN_W-1:0] fill;  // entries written so far
  } acg_ctrl_t;

endpackage
`default_nettype wire

/* rtl/acg_cell.sv */
`default_nettype none
module acg_cell #(
  parameter int MAX_CADENCE = acg_pkg::MAX_CADENCE_DEF,
  parameter int CELL_IDX    = 0
) (
  input  wire logic                                        clk,
  input  wire acg_pkg::acg_ctrl_t                          ctrl,
  input  wire logic [MAX_CADENCE-1:0][acg_pkg::DATA_W-1:0] words,
  input  wire logic [acg_pkg::DATA_W-1:0]                  count,
  input  wire logic [acg_pkg::DATA_W-1:0]                  right_entry,
  input  wire logic                                        match_in,
  output logic      [acg_pkg::DATA_W-1:0]                  entry,
  output logic                                             match_out
);

  localparam int IW = (MAX_CADENCE > 1) ? $clog2(MAX_CADENCE) : 1;
  localparam int SW = acg_pkg::LEN_W + 1;

  logic          active;
  logic          is_tail;
  logic          is_fill;
  logic [SW-1:0] len_ext;
  logic [SW-1:0] sum;
  logic [SW-1:0] idx;
  logic [acg_pkg::DATA_W-1:0] expected;

  assign len_ext = {1'b0, ctrl.len};
  assign active  = SW'(CELL_IDX) < len_ext;
  assign is_tail = (SW'(CELL_IDX) + SW'(1)) == len_ext;
  assign is_fill = SW'(CELL_IDX) == {1'b0, ctrl.fill};

  // cadence word this cell should hold: (off + idx) mod len
  assign sum      = {1'b0, ctrl.off} + SW'(CELL_IDX);
  assign idx      = (sum >= len_ext) ? (sum - len_ext) : sum;
  assign expected = words[idx[IW-1:0]];

  assign match_out = match_in & (!active | (entry == expected));

  always_ff @(posedge clk) begin
    if (ctrl.load && active) begin
      if (ctrl.full) begin
        entry <= is_tail ? count : right_entry;
      end else if (is_fill) begin
        entry <= count;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/audio_cadence_guard.sv */
`default_nettype none
// Frame gate for audio cadence: each item carries one video frame's audio
// sample count and yields one flag, forward, that says whether the frame may
// pass. One item is taken every clock unless the sink holds back a waiting flag;
// its flag is registered on acceptance, and a new item is taken while that flag
// waits as long as the sink takes it in the same cycle. The last counts sit in a
// row of MAX_CADENCE history cells that shift toward the head; each cell
// compares its entry with its rotated cadence word and the results ripple
// down the row, so the row length sets the compare depth. A length of 0 or 1
// forwards every frame. Any write to registers 0..5 restarts tracking
// (history empty, rotation zero); writes to higher indexes are ignored.
module audio_cadence_guard #(
  parameter int MAX_CADENCE = acg_pkg::MAX_CADENCE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,   // [15:0] audio_count
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [7:0]                        m_tdata,   // [0] forward, [7:1] zero
  input  wire logic                              cfg_we,
  input  wire logic [acg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [acg_pkg::DATA_W-1:0]        cfg_data
);

  localparam int IW = (MAX_CADENCE > 1) ? $clog2(MAX_CADENCE) : 1;
  localparam int LW = acg_pkg::LEN_W;

  logic [LW-1:0] len_reg;
  logic [MAX_CADENCE-1:0][acg_pkg::DATA_W-1:0] words;
  logic [LW-1:0] fill;
  logic [LW-1:0] offset;
  logic          fwd_reg;

  logic [LW-1:0] eff_len;
  logic          bypass;
  logic          accept;
  logic          full;
  logic          fwd;
  logic          cfg_hit;
  logic [acg_pkg::DATA_W-1:0] count;
  acg_pkg::acg_ctrl_t ctrl;

  logic [acg_pkg::DATA_W-1:0] entry [MAX_CADENCE];
  logic [MAX_CADENCE:0]       match;

  assign count    = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, fwd_reg};

  always_comb begin
    if (len_reg == '0) begin
      eff_len = LW'(1);
    end else if ({1'b0, len_reg} > (LW + 1)'(MAX_CADENCE)) begin
      eff_len = LW'(MAX_CADENCE);
    end else begin
      eff_len = len_reg;
    end
  end

  assign bypass  = eff_len == LW'(1);
  assign full    = fill >= eff_len;
  assign cfg_hit = cfg_we && (cfg_index <= acg_pkg::REG_WORD_LAST);

  assign ctrl.load = accept && !bypass;
  assign ctrl.full = full;
  assign ctrl.len  = eff_len;
  assign ctrl.off  = offset;
  assign ctrl.fill = fill;

  assign match[0] = 1'b1;

  for (genvar i = 0; i < MAX_CADENCE; i++) begin : g_cell
    logic [acg_pkg::DATA_W-1:0] right;
    if (i == MAX_CADENCE - 1) begin : g_last
      assign right = count;
    end else begin : g_mid
      assign right = entry[i+1];
    end
    acg_cell #(
      .MAX_CADENCE (MAX_CADENCE),
      .CELL_IDX    (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .words       (words),
      .count       (count),
      .right_entry (right),
      .match_in    (match[i]),
      .entry       (entry[i]),
      .match_out   (match[i+1])
    );
  end

  // head word is the one the current count must match
  assign fwd = bypass || (full && match[MAX_CADENCE] && (count == words[offset[IW-1:0]]));

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LW'(1);
      words   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == acg_pkg::REG_LENGTH) begin
        len_reg <= cfg_data[LW-1:0];
      end
      for (int w = 0; w < MAX_CADENCE; w++) begin
        if (w < acg_pkg::NUM_WORD_REGS &&
            cfg_index == acg_pkg::REG_WORD_0 + acg_pkg::CFG_IDX_W'(w)) begin
          words[w] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      offset <= '0;
    end else if (cfg_hit) begin
      fill   <= '0;
      offset <= '0;
    end else if (accept && !bypass) begin
      if (!full) begin
        fill <= fill + LW'(1);
      end
      if (fwd) begin
        offset <= (offset + LW'(1) == eff_len) ? '0 : offset + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_reg <= fwd;
    end
  end

endmodule
`default_nettype wire
